>>> rtl/core/lbu_pkg.sv
package lbu_pkg;

  // Field widths of the channels and registers.
  localparam int COLOR_W    = 8;
  localparam int HEIGHT_W   = 16;
  localparam int COORD_W    = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_INDEX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;

  // Defaults of the size parameters and the register reset value.
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;
  localparam logic [CFG_DATA_W-1:0] RESET_DIM = 11'd1024;

  // Rec.709 weights scaled so that they sum to 65536.
  localparam logic [23:0] W_RED   = 24'd13933;
  localparam logic [23:0] W_GREEN = 24'd46871;
  localparam logic [23:0] W_BLUE  = 24'd4732;

  // The height is round(P * 65535 / (65536 * 65025)) with P = weighted sum times alpha.
  localparam logic [47:0] HALF_DEN = 48'd2130739200;
  localparam logic [17:0] DIVISOR  = 18'd65025;
  // floor(2^32 / 65025), the reciprocal used for the division by 65025.
  localparam logic [16:0] RECIP    = 17'd66051;

  // Output blocks emitted by a pixel, in emission order.
  localparam logic [1:0] BLK_UP_LEFT = 2'd0;
  localparam logic [1:0] BLK_UP      = 2'd1;
  localparam logic [1:0] BLK_LEFT    = 2'd2;
  localparam logic [1:0] BLK_HERE    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } lbu_state_t;

  // Controls of the sequencer.
  typedef struct packed {
    logic take;
    logic mem_read;
    logic mem_write;
    logic load_out;
  } lbu_ctl_t;

endpackage

>>> rtl/core/lbu_ifs.sv
interface lbu_pix_if import lbu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface lbu_sample_if import lbu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [HEIGHT_W-1:0] height;
  logic                last_of_run;

  modport source (output valid, out_x, out_y, height, last_of_run, input ready);
  modport sink (input valid, out_x, out_y, height, last_of_run, output ready);
endinterface

interface lbu_cfg_if import lbu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/lbu_luma.sv
// Five-stage pipeline from an RGBA pixel to its 16-bit height. All stages
// advance together whenever the last stage is empty or its height is taken.
module lbu_luma
  import lbu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  lbu_pix_if.sink             pix,
  input  logic                take,
  output logic                height_valid,
  output logic [HEIGHT_W-1:0] height
);

  logic [4:0]          stage_valid;
  logic                advance;
  logic [23:0]         wsum;
  logic [COLOR_W-1:0]  pix_alpha_d;
  logic [31:0]         prod;
  logic [31:0]         quo_in;
  logic [31:0]         quo_in_d;
  logic [15:0]         quo_est;
  logic [47:0]         scaled;
  logic [63:0]         recip_prod;
  logic [17:0]         rem;
  logic [HEIGHT_W-1:0] result;

  assign advance      = !stage_valid[4] || take;
  assign pix.ready    = advance;
  assign height_valid = stage_valid[4];
  assign height       = result;

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[3:0], pix.valid};
    end
  end

  // Rounded M = floor((P * 65535 + D / 2) / 65536), then M / 65025.
  assign scaled     = (48'(prod) << 16) - 48'(prod) + HALF_DEN;
  assign recip_prod = 64'(quo_in) * 64'(RECIP);
  assign rem        = quo_in_d[17:0] - 18'(32'(quo_est) * 32'(DIVISOR));

  always_ff @(posedge clk) begin
    if (advance) begin
      wsum     <= W_RED * 24'(pix.red) + W_GREEN * 24'(pix.green) + W_BLUE * 24'(pix.blue);
      prod     <= 32'(wsum) * 32'(pix_alpha_d);
      quo_in   <= scaled[47:16];
      quo_est  <= recip_prod[47:32];
      quo_in_d <= quo_in;
      // The reciprocal estimate is low by at most one.
      result   <= (rem >= DIVISOR) ? quo_est + 16'd1 : quo_est;
    end
  end

  // Alpha travels alongside the weighted sum.
  always_ff @(posedge clk) begin
    if (advance) begin
      pix_alpha_d <= pix.alpha;
    end
  end

endmodule

>>> rtl/core/luma_bilinear_upscale_2x_unit.sv
// Streaming 2x bilinear upscaler of a luma heightmap. Source RGBA pixels enter
// in raster order; each is turned into a 16-bit height (Rec.709 luma times
// alpha) by a five-stage pipeline, and a line memory keeps the previous source
// row. In the sequencer a pixel first has the line memory read, then writeback
// and setup, and then the emit phase loads its 0, 4, 8 or 16 results into the
// single output register, one result per cycle while the output is not stalled.
// The luma pipeline overlaps with the emit phase. A write to either size
// register restarts the frame at the top left corner.
module luma_bilinear_upscale_2x_unit
  import lbu_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  lbu_pix_if.sink     pix,
  lbu_sample_if.source sample,
  lbu_cfg_if.sink     cfg
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  // Index of the last column or row for a written dimension.
  function automatic int dim_last(input logic [CFG_DATA_W-1:0] v, input int maxv);
    int vi;
    vi = int'(v);
    if (vi == 0) return 0;
    if (vi > maxv) return maxv - 1;
    return vi - 1;
  endfunction

  // Lowest set bit of a block mask.
  function automatic logic [1:0] first_blk(input logic [3:0] m);
    logic [1:0] idx;
    idx = BLK_UP_LEFT;
    for (int i = 3; i >= 0; i--) begin
      if (m[i]) idx = 2'(i);
    end
    return idx;
  endfunction

  lbu_state_t          state;
  lbu_state_t          state_next;
  lbu_ctl_t            ctl;

  logic                luma_valid;
  logic [HEIGHT_W-1:0] luma_height;

  logic [XW-1:0]       last_x;
  logic [YW-1:0]       last_y;
  logic [XW-1:0]       cfg_last_x;
  logic [YW-1:0]       cfg_last_y;
  logic [XW-1:0]       column_count;
  logic [YW-1:0]       row_count;
  logic [HEIGHT_W-1:0] left_current;
  logic [HEIGHT_W-1:0] left_above;
  logic [HEIGHT_W-1:0] cur_h;

  logic [HEIGHT_W-1:0] row_mem [MAX_WIDTH];
  logic [HEIGHT_W-1:0] rd_data;

  logic                last_col;
  logic                last_row;
  logic [3:0]          mask_now;
  logic [HEIGHT_W-1:0] above_now;

  logic [XW-1:0]       px;
  logic [YW-1:0]       py;
  logic [HEIGHT_W-1:0] s_cur;
  logic [HEIGHT_W-1:0] s_above;
  logic [HEIGHT_W-1:0] s_left;
  logic [HEIGHT_W-1:0] s_la;
  logic [3:0]          mask;
  logic [1:0]          blk;
  logic [1:0]          sub;

  logic                out_free;
  logic [3:0]          rest_mask;
  logic                item_last;
  logic [XW-1:0]       bx;
  logic [YW-1:0]       by;
  logic [HEIGHT_W-1:0] va, vb, vc, vd;
  logic [16:0]         avg_ab, avg_ac;
  logic [17:0]         avg_all;
  logic [HEIGHT_W-1:0] item_h;
  logic                out_valid;

  lbu_luma u_luma (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix),
    .take         (ctl.take),
    .height_valid (luma_valid),
    .height       (luma_height)
  );

  // Configuration port: always ready, decoded dimensions kept as last indexes.
  assign cfg.ready  = 1'b1;
  assign cfg_last_x = XW'(dim_last(cfg.data, MAX_WIDTH));
  assign cfg_last_y = YW'(dim_last(cfg.data, MAX_HEIGHT));

  // Position of the pixel in hand.
  assign last_col  = (column_count == last_x);
  assign last_row  = (row_count == last_y);
  assign above_now = (row_count != '0) ? rd_data : '0;
  assign mask_now  = {last_row && last_col,
                      last_row && (column_count != '0),
                      (row_count != '0) && last_col,
                      (row_count != '0) && (column_count != '0)};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (luma_valid) state_next = ST_SETUP;
      ST_SETUP: state_next = (mask_now != '0) ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_free && item_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer controls.
  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.take     = luma_valid;
        ctl.mem_read = luma_valid;
      end
      ST_SETUP: ctl.mem_write = 1'b1;
      ST_EMIT:  ctl.load_out = out_free;
      default:  ctl = '0;
    endcase
  end

  // Line memory: the previous row, read at the pixel's column and written back.
  always_ff @(posedge clk) begin
    if (ctl.mem_write) begin
      row_mem[column_count] <= cur_h;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_read) begin
      rd_data <= row_mem[column_count];
    end
  end

  // Control registers: dimensions, position, left neighbors, emit cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x       <= XW'(dim_last(RESET_DIM, MAX_WIDTH));
      last_y       <= YW'(dim_last(RESET_DIM, MAX_HEIGHT));
      column_count <= '0;
      row_count    <= '0;
      left_current <= '0;
      left_above   <= '0;
      mask         <= '0;
      blk          <= BLK_UP_LEFT;
      sub          <= '0;
    end else begin
      if (state == ST_SETUP) begin
        left_current <= cur_h;
        left_above   <= above_now;
        mask         <= mask_now;
        blk          <= first_blk(mask_now);
        sub          <= '0;
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end else if (ctl.load_out) begin
        if (sub == 2'd3) begin
          blk <= first_blk(rest_mask);
          sub <= '0;
        end else begin
          sub <= sub + 2'd1;
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SRC_WIDTH: begin
            last_x       <= cfg_last_x;
            column_count <= '0;
            row_count    <= '0;
          end
          REG_SRC_HEIGHT: begin
            last_y       <= cfg_last_y;
            column_count <= '0;
            row_count    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Pixel data held for the emit phase.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cur_h <= luma_height;
    end
    if (state == ST_SETUP) begin
      px      <= column_count;
      py      <= row_count;
      s_cur   <= cur_h;
      s_above <= above_now;
      s_left  <= left_current;
      s_la    <= left_above;
    end
  end

  // Blocks still to come after the current one.
  assign rest_mask = mask & ~(4'((5'd1 << ({1'b0, blk} + 3'd1)) - 5'd1));
  assign item_last = (sub == 2'd3) && (rest_mask == '0);

  // Corners and source position of the current block.
  always_comb begin
    bx = blk[0] ? px : px - 1'b1;
    by = blk[1] ? py : py - 1'b1;
    va = s_cur;
    vb = s_cur;
    vc = s_cur;
    vd = s_cur;
    unique case (blk)
      BLK_UP_LEFT: begin
        va = s_la;
        vb = s_above;
        vc = s_left;
      end
      BLK_UP: begin
        va = s_above;
        vb = s_above;
      end
      BLK_LEFT: begin
        va = s_left;
        vc = s_left;
      end
      BLK_HERE: ;
      default: ;
    endcase
  end

  // Rounded averages of the block corners.
  assign avg_ab  = 17'(va) + 17'(vb) + 17'd1;
  assign avg_ac  = 17'(va) + 17'(vc) + 17'd1;
  assign avg_all = 18'(va) + 18'(vb) + 18'(vc) + 18'(vd) + 18'd2;

  always_comb begin
    case (sub)
      2'd0:    item_h = va;
      2'd1:    item_h = avg_ab[16:1];
      2'd2:    item_h = avg_ac[16:1];
      default: item_h = avg_all[17:2];
    endcase
  end

  // Output register.
  assign out_free     = !out_valid || sample.ready;
  assign sample.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (sample.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      sample.out_x       <= COORD_W'({bx, sub[0]});
      sample.out_y       <= COORD_W'({by, sub[1]});
      sample.height      <= item_h;
      sample.last_of_run <= item_last;
    end
  end

`ifndef SYNTH
  // The line memory is never read and written in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(ctl.mem_read && ctl.mem_write))
    else $error("line memory read and write overlap");

  // Setup always follows the cycle in which a pixel was taken.
  assert property (@(posedge clk) disable iff (rst) (state == ST_SETUP) |-> $past(ctl.take))
    else $error("setup without a taken pixel");

  // The emit cursor only visits enabled blocks.
  assert property (@(posedge clk) disable iff (rst) (state == ST_EMIT) |-> mask[blk])
    else $error("emit cursor on a disabled block");

  // Loading the final result of a pixel ends the emit phase.
  assert property (@(posedge clk) disable iff (rst)
    (ctl.load_out && item_last) |=> (state == ST_IDLE))
    else $error("emit phase did not end after the final result");

  // The column never passes the last column.
  assert property (@(posedge clk) disable iff (rst) column_count <= last_x)
    else $error("column position past the last column");
`endif

endmodule
